// File: hw/rtl/sca_pkg.sv
`default_nettype none

package sca_pkg;

   // Defaults for the top-level parameters.
   localparam int WAYS_DEF      = 8;
   localparam int SET_COUNT_DEF = 128;
   localparam int TAG_BITS_DEF  = 13;

   // Fixed field layout of the request and response words.
   localparam int ADDR_W      = 25;
   localparam int CMD_W       = 2;
   localparam int OUT_WAY_W   = 3;
   localparam int OFF_W       = 5;
   localparam int SET_LSB     = 5;
   localparam int SET_FIELD_W = 7;
   localparam int TAG_LSB     = 12;
   localparam int TAG_FIELD_W = 13;
   localparam int LINE_W      = ADDR_W - OFF_W;

   // Replacement counters.
   localparam int AGE_W = 3;
   localparam logic [AGE_W-1:0] AGE_TOP = 3'h7;

   // Widest way index, tag and set index over the parameter ranges.
   localparam int WAY_IDX_W = 4;
   localparam int MAX_TAG_W = 32;
   localparam int MAX_SET_W = 12;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PROBE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd3;

   // One response word.
   typedef struct packed {
      logic                 hit;
      logic [OUT_WAY_W-1:0] way;
      logic                 writeback_valid;
      logic [ADDR_W-1:0]    writeback_addr;
      logic                 fill_valid;
      logic [ADDR_W-1:0]    fill_addr;
      logic                 last_result;
   } rsp_type;

   // Status of the way scan: accumulated results and the way under the pointer.
   typedef struct packed {
      logic                 hit_found;
      logic [WAY_IDX_W-1:0] hit_way;
      logic                 inv_found;
      logic [WAY_IDX_W-1:0] inv_way;
      logic [WAY_IDX_W-1:0] best_way;
      logic                 cur_dirty;
      logic                 cur_last;
      logic [ADDR_W-1:0]    cur_line_addr;
      logic                 any_dirty;
   } scan_res_type;

   // Line address built from a stored tag and a set index, offset bits zero.
   function automatic logic [ADDR_W-1:0] line_addr(input logic [MAX_TAG_W-1:0] tag_in,
                                                   input logic [MAX_SET_W-1:0] set_in);
      line_addr = {tag_in[TAG_FIELD_W-1:0], set_in[SET_FIELD_W-1:0], {OFF_W{1'b0}}};
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/set_assoc_writeback_cache_ctrl.sv
`default_nettype none

// Tag and replacement controller of a set-associative write-back cache with a
// 13-bit tag, 7-bit set and 5-bit offset address split. After reset the block
// clears the tag memory, one set per cycle, and holds req_ready low meanwhile.
// Each request then reads its whole set in one memory access and a single
// tag/counter comparator walks the ways one per cycle, unless a flush word
// waits for the output register. A probe, fill or write passes through the
// load, scan and decide states and has its response word loaded into the
// output register in the decide state; the next request can be accepted in
// the cycle after that. A set flush walks the ways the same way and emits one
// word per dirty way as the walk reaches it, or a single word from the decide
// state when no way is dirty. Whenever a new word must be loaded while the
// output register still holds a word that the consumer has not taken, the
// walk or its final step waits until rsp_ready takes that word. One request
// is worked on at a time; the next is accepted while the last word still
// waits in the output register.
module set_assoc_writeback_cache_ctrl import sca_pkg::*; #(
   parameter int WAYS      = WAYS_DEF,
   parameter int SET_COUNT = SET_COUNT_DEF,
   parameter int TAG_BITS  = TAG_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [ADDR_W-1:0]    req_addr,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_hit,
   output logic      [OUT_WAY_W-1:0] rsp_way,
   output logic                      rsp_writeback_valid,
   output logic      [ADDR_W-1:0]    rsp_writeback_addr,
   output logic                      rsp_fill_valid,
   output logic      [ADDR_W-1:0]    rsp_fill_addr,
   output logic                      rsp_last_result
);

   localparam int WayW    = $clog2(WAYS);
   localparam int SetW    = $clog2(SET_COUNT);
   localparam int EntW    = TAG_BITS + AGE_W + 2;
   localparam int RowW    = WAYS * EntW;
   localparam int SetRefs = 2 ** SET_FIELD_W;

   // Sequencer states.
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [SetW-1:0]            clr_ff, clr_in;
   logic [WayW-1:0]            idx_ff, idx_in;
   logic [CMD_W-1:0]           cmd_ff;
   logic [TAG_BITS-1:0]        tag_ff;
   logic [SetW-1:0]            set_ff;
   logic [LINE_W-1:0]          line_ff;
   logic [WAYS-1:0][EntW-1:0]  row_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff;

   logic                       accept;
   logic                       out_free;
   logic                       advance;
   logic                       emit;
   logic                       load_out;
   rsp_type                    out_word;
   rsp_type                    flush_word;
   logic                       scan_start;
   logic                       scan_step;
   scan_res_type               sr;
   logic [WAYS-1:0][EntW-1:0]  upd_row;
   rsp_type                    upd_rsp;
   logic                       ram_we;
   logic [SetW-1:0]            ram_waddr;
   logic [WAYS-1:0][EntW-1:0]  ram_wdata;
   logic [RowW-1:0]            ram_rd_data;
   logic [SetW-1:0]            req_set;
   logic [SetW-1:0]            set_mod_lut [SetRefs];

   // Set field folded onto the number of sets.
   for (genvar g = 0; g < SetRefs; g++) begin : g_set_mod
      assign set_mod_lut[g] = SetW'(g % SET_COUNT);
   end

   assign req_set   = set_mod_lut[req_addr[SET_LSB +: SET_FIELD_W]];
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Tag, dirty, valid and counter memory, one row per set.
   sca_ram #(
      .WIDTH (RowW),
      .DEPTH (SET_COUNT)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (ram_rd_data)
   );

   // Shared comparator that walks the ways of the set.
   sca_way_scan #(
      .WAYS      (WAYS),
      .SET_COUNT (SET_COUNT),
      .TAG_BITS  (TAG_BITS)
   ) u_scan (
      .clock   (clock),
      .start   (scan_start),
      .step    (scan_step),
      .idx     (idx_ff),
      .tag     (tag_ff),
      .set_idx (set_ff),
      .row     (row_ff),
      .res     (sr)
   );

   // New set contents and response word once the walk is done.
   sca_row_update #(
      .WAYS      (WAYS),
      .SET_COUNT (SET_COUNT),
      .TAG_BITS  (TAG_BITS)
   ) u_update (
      .row     (row_ff),
      .cmd     (cmd_ff),
      .tag     (tag_ff),
      .set_idx (set_ff),
      .line    (line_ff),
      .sr      (sr),
      .new_row (upd_row),
      .rsp     (upd_rsp)
   );

   // Word for one dirty way of a flushed set.
   always_comb begin
      flush_word                 = '0;
      flush_word.way             = OUT_WAY_W'(idx_ff);
      flush_word.writeback_valid = 1'b1;
      flush_word.writeback_addr  = sr.cur_line_addr;
      flush_word.last_result     = sr.cur_last;
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      idx_in     = idx_ff;
      scan_start = 1'b0;
      scan_step  = 1'b0;
      advance    = 1'b0;
      emit       = 1'b0;
      load_out   = 1'b0;
      out_word   = upd_rsp;
      ram_we     = 1'b0;
      ram_waddr  = set_ff;
      ram_wdata  = upd_row;
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == SetW'(SET_COUNT - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            scan_start = 1'b1;
            idx_in     = '0;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            advance = 1'b1;
            if ((cmd_ff == CMD_FLUSH) && sr.cur_dirty) begin
               advance  = out_free;
               load_out = out_free;
               out_word = flush_word;
            end
            if (advance) begin
               scan_step = 1'b1;
               if (idx_ff == WayW'(WAYS - 1)) begin
                  state_in = S_DECIDE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_DECIDE: begin
            emit = (cmd_ff != CMD_FLUSH) || !sr.any_dirty;
            if (!emit || out_free) begin
               load_out = emit;
               ram_we   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request, working set and response registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept) begin
         cmd_ff  <= req_cmd;
         tag_ff  <= TAG_BITS'(req_addr[TAG_LSB +: TAG_FIELD_W]);
         set_ff  <= req_set;
         line_ff <= req_addr[OFF_W +: LINE_W];
      end
      if (state_ff == S_LOAD) begin
         row_ff <= ram_rd_data;
      end
      if (load_out) begin
         rsp_ff <= out_word;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_ff.hit;
   assign rsp_way             = rsp_ff.way;
   assign rsp_writeback_valid = rsp_ff.writeback_valid;
   assign rsp_writeback_addr  = rsp_ff.writeback_addr;
   assign rsp_fill_valid      = rsp_ff.fill_valid;
   assign rsp_fill_addr       = rsp_ff.fill_addr;
   assign rsp_last_result     = rsp_ff.last_result;

endmodule

`default_nettype wire

// File: hw/rtl/sca_ram.sv
`default_nettype none

module sca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/sca_way_scan.sv
`default_nettype none

module sca_way_scan import sca_pkg::*; #(
   parameter int WAYS      = WAYS_DEF,
   parameter int SET_COUNT = SET_COUNT_DEF,
   parameter int TAG_BITS  = TAG_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  start,
   input  wire logic                                  step,
   input  wire logic [$clog2(WAYS)-1:0]               idx,
   input  wire logic [TAG_BITS-1:0]                   tag,
   input  wire logic [$clog2(SET_COUNT)-1:0]          set_idx,
   input  wire logic [WAYS-1:0][TAG_BITS+AGE_W+1:0]   row,
   output scan_res_type                               res
);

   localparam int WayW     = $clog2(WAYS);
   localparam int DirtyBit = TAG_BITS + AGE_W;

   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [TAG_BITS-1:0] tag;
      logic [AGE_W-1:0]    age;
   } entry_type;

   entry_type        cur;
   logic             match;
   logic [WAYS-1:0]  dirty_vec;
   logic [WAYS-1:0]  above_vec;

   logic             hit_found_ff, hit_found_in;
   logic [WayW-1:0]  hit_way_ff, hit_way_in;
   logic             inv_found_ff, inv_found_in;
   logic [WayW-1:0]  inv_way_ff, inv_way_in;
   logic [WayW-1:0]  best_way_ff, best_way_in;
   logic [AGE_W-1:0] best_age_ff, best_age_in;

   // The way under the pointer and per-way dirty status.
   always_comb begin
      cur   = entry_type'(row[idx]);
      match = cur.valid && (cur.tag == tag);
      for (int i = 0; i < WAYS; i++) begin
         dirty_vec[i] = row[i][DirtyBit];
         above_vec[i] = (WayW'(i) > idx);
      end
   end

   // One way per step: first hit, first invalid way, first lowest counter.
   always_comb begin
      hit_found_in = hit_found_ff;
      hit_way_in   = hit_way_ff;
      inv_found_in = inv_found_ff;
      inv_way_in   = inv_way_ff;
      best_way_in  = best_way_ff;
      best_age_in  = best_age_ff;
      if (start) begin
         hit_found_in = 1'b0;
         hit_way_in   = '0;
         inv_found_in = 1'b0;
         inv_way_in   = '0;
         best_way_in  = '0;
         best_age_in  = '0;
      end else if (step) begin
         if (match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_way_in   = idx;
         end
         if (!cur.valid && !inv_found_ff) begin
            inv_found_in = 1'b1;
            inv_way_in   = idx;
         end
         if ((idx == '0) || (cur.age < best_age_ff)) begin
            best_way_in = idx;
            best_age_in = cur.age;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_found_ff <= hit_found_in;
      hit_way_ff   <= hit_way_in;
      inv_found_ff <= inv_found_in;
      inv_way_ff   <= inv_way_in;
      best_way_ff  <= best_way_in;
      best_age_ff  <= best_age_in;
   end

   // Status toward the sequencer.
   always_comb begin
      res.hit_found     = hit_found_ff;
      res.hit_way       = WAY_IDX_W'(hit_way_ff);
      res.inv_found     = inv_found_ff;
      res.inv_way       = WAY_IDX_W'(inv_way_ff);
      res.best_way      = WAY_IDX_W'(best_way_ff);
      res.cur_dirty     = cur.dirty;
      res.cur_last      = ~|(dirty_vec & above_vec);
      res.cur_line_addr = line_addr(MAX_TAG_W'(cur.tag), MAX_SET_W'(set_idx));
      res.any_dirty     = |dirty_vec;
   end

endmodule

`default_nettype wire

// File: hw/rtl/sca_row_update.sv
`default_nettype none

module sca_row_update import sca_pkg::*; #(
   parameter int WAYS      = WAYS_DEF,
   parameter int SET_COUNT = SET_COUNT_DEF,
   parameter int TAG_BITS  = TAG_BITS_DEF
) (
   input  wire logic [WAYS-1:0][TAG_BITS+AGE_W+1:0] row,
   input  wire logic [CMD_W-1:0]                    cmd,
   input  wire logic [TAG_BITS-1:0]                 tag,
   input  wire logic [$clog2(SET_COUNT)-1:0]        set_idx,
   input  wire logic [LINE_W-1:0]                   line,
   input  scan_res_type                             sr,
   output logic      [WAYS-1:0][TAG_BITS+AGE_W+1:0] new_row,
   output rsp_type                                  rsp
);

   localparam int WayW = $clog2(WAYS);

   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [TAG_BITS-1:0] tag;
      logic [AGE_W-1:0]    age;
   } entry_type;

   entry_type       ent;
   entry_type       old;
   logic [WayW-1:0] victim;
   logic [WayW-1:0] use_way;
   logic            touch_en;
   logic            install;
   logic            set_dirty;
   logic            clear_dirty;

   // Decode the command into actions on the set.
   always_comb begin
      victim      = sr.inv_found ? WayW'(sr.inv_way) : WayW'(sr.best_way);
      use_way     = victim;
      touch_en    = 1'b0;
      install     = 1'b0;
      set_dirty   = 1'b0;
      clear_dirty = 1'b0;
      case (cmd)
         CMD_PROBE: begin
            if (sr.hit_found) begin
               use_way  = WayW'(sr.hit_way);
               touch_en = 1'b1;
            end
         end
         CMD_FILL: begin
            touch_en = 1'b1;
            install  = 1'b1;
         end
         CMD_WRITE: begin
            touch_en  = 1'b1;
            set_dirty = 1'b1;
            if (sr.hit_found) begin
               use_way = WayW'(sr.hit_way);
            end else begin
               install = 1'b1;
            end
         end
         CMD_FLUSH: begin
            clear_dirty = 1'b1;
         end
         default: begin
            clear_dirty = 1'b0;
         end
      endcase
   end

   // New contents of the set: counters, install and dirty marks.
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         ent = entry_type'(row[i]);
         if (touch_en) begin
            if (WayW'(i) == use_way) begin
               ent.age = AGE_TOP;
            end else if (ent.age != '0) begin
               ent.age = ent.age - AGE_W'(1);
            end
         end
         if (install && (WayW'(i) == use_way)) begin
            ent.valid = 1'b1;
            ent.dirty = 1'b0;
            ent.tag   = tag;
         end
         if (set_dirty && (WayW'(i) == use_way)) begin
            ent.dirty = 1'b1;
         end
         if (clear_dirty) begin
            ent.dirty = 1'b0;
         end
         new_row[i] = ent;
      end
   end

   // Response word; a dirty victim is reported with its old line address.
   always_comb begin
      old             = entry_type'(row[use_way]);
      rsp             = '0;
      rsp.last_result = 1'b1;
      rsp.hit         = touch_en && !install;
      if (touch_en) begin
         rsp.way = OUT_WAY_W'(use_way);
      end
      if (install) begin
         rsp.writeback_valid = old.dirty;
         if (old.dirty) begin
            rsp.writeback_addr = line_addr(MAX_TAG_W'(old.tag), MAX_SET_W'(set_idx));
         end
         rsp.fill_valid = 1'b1;
         rsp.fill_addr  = {line, {OFF_W{1'b0}}};
      end
   end

endmodule

`default_nettype wire

// File: tb/set_assoc_writeback_cache_ctrl_tb.sv
`timescale 1ns / 100ps

module set_assoc_writeback_cache_ctrl_tb;
   import sca_pkg::*;

   localparam int NUM_WAYS     = WAYS_DEF;
   localparam int NUM_SETS     = SET_COUNT_DEF;
   localparam int RAND_WORDS   = 350;
   localparam int IDLE_PCT     = 36;
   localparam int CALM_FIRST   = 120;
   localparam int CALM_LAST    = 220;
   localparam int DRAIN_CYCLES = 4 * (NUM_WAYS + 3);
   localparam int STUCK_LIMIT  = 3000;
   localparam int TAG_POOL     = 12;

   // One row of the directed stimulus table.
   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] addr;
      bit                typed;
      rsp_type           word;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_cmd = CMD_PROBE;
   logic [ADDR_W-1:0]    req_addr = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic [OUT_WAY_W-1:0] rsp_way;
   logic                 rsp_writeback_valid;
   logic [ADDR_W-1:0]    rsp_writeback_addr;
   logic                 rsp_fill_valid;
   logic [ADDR_W-1:0]    rsp_fill_addr;
   logic                 rsp_last_result;

   // Shadow copy of the tag and counter arrays.
   logic                   line_valid [NUM_SETS][NUM_WAYS];
   logic                   line_dirty [NUM_SETS][NUM_WAYS];
   logic [TAG_FIELD_W-1:0] line_tag   [NUM_SETS][NUM_WAYS];
   logic [AGE_W-1:0]       line_age   [NUM_SETS][NUM_WAYS];

   rsp_type      awaited_words [$];
   rsp_type      fresh_words [$];
   stim_row_type stim_rows [$];
   int           mismatch_count = 0;
   int           stuck_cycles = 0;
   bit           calm = 1'b0;

   set_assoc_writeback_cache_ctrl dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_addr            (req_addr),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_way             (rsp_way),
      .rsp_writeback_valid (rsp_writeback_valid),
      .rsp_writeback_addr  (rsp_writeback_addr),
      .rsp_fill_valid      (rsp_fill_valid),
      .rsp_fill_addr       (rsp_fill_addr),
      .rsp_last_result     (rsp_last_result)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic rsp_type make_word(input logic hit, input int way, input logic wbv,
                                         input logic [ADDR_W-1:0] wba, input logic fv,
                                         input logic [ADDR_W-1:0] fa, input logic last);
      rsp_type w;
      w.hit             = hit;
      w.way             = way[OUT_WAY_W-1:0];
      w.writeback_valid = wbv;
      w.writeback_addr  = wba;
      w.fill_valid      = fv;
      w.fill_addr       = fa;
      w.last_result     = last;
      return w;
   endfunction

   // The used way becomes most recent; every other way ages by one, floored at zero.
   function automatic void touch_set(input int s, input int mru);
      int w;
      for (w = 0; w < NUM_WAYS; w++) begin
         if (w == mru) begin
            line_age[s][w] = AGE_TOP;
         end else if (line_age[s][w] != '0) begin
            line_age[s][w] = line_age[s][w] - 1'b1;
         end
      end
   endfunction

   function automatic int find_way(input int s, input logic [TAG_FIELD_W-1:0] tag);
      int w;
      for (w = 0; w < NUM_WAYS; w++) begin
         if (line_valid[s][w] && line_tag[s][w] == tag) return w;
      end
      return -1;
   endfunction

   // First invalid way, otherwise the first way holding the lowest count.
   function automatic int pick_victim(input int s);
      int w;
      int best;
      best = 0;
      for (w = 0; w < NUM_WAYS; w++) begin
         if (!line_valid[s][w]) return w;
      end
      for (w = 1; w < NUM_WAYS; w++) begin
         if (line_age[s][w] < line_age[s][best]) best = w;
      end
      return best;
   endfunction

   function automatic logic [ADDR_W-1:0] stored_line(input int s, input int w);
      return {line_tag[s][w], s[SET_FIELD_W-1:0], {OFF_W{1'b0}}};
   endfunction

   // Installs a line over the victim and queues the fill word.
   function automatic int install_line(input int s, input logic [ADDR_W-1:0] addr);
      int v;
      logic wbv;
      logic [ADDR_W-1:0] wba;
      v   = pick_victim(s);
      wbv = line_dirty[s][v];
      wba = wbv ? stored_line(s, v) : '0;
      line_valid[s][v] = 1'b1;
      line_dirty[s][v] = 1'b0;
      line_tag[s][v]   = addr[ADDR_W-1:TAG_LSB];
      touch_set(s, v);
      fresh_words.push_back(make_word(1'b0, v, wbv, wba, 1'b1,
                                      {addr[ADDR_W-1:OFF_W], {OFF_W{1'b0}}}, 1'b1));
      return v;
   endfunction

   // Applies one command to the shadow arrays and queues the words it produces.
   function automatic void apply_cache_cmd(input logic [CMD_W-1:0] cmd,
                                           input logic [ADDR_W-1:0] addr);
      int s;
      int w;
      int n;
      logic [TAG_FIELD_W-1:0] tag;
      s   = int'(addr[TAG_LSB-1:SET_LSB]) % NUM_SETS;
      tag = addr[ADDR_W-1:TAG_LSB];
      n   = 0;
      case (cmd)
         CMD_PROBE: begin
            w = find_way(s, tag);
            if (w >= 0) begin
               touch_set(s, w);
               fresh_words.push_back(make_word(1'b1, w, 1'b0, '0, 1'b0, '0, 1'b1));
            end else begin
               fresh_words.push_back(make_word(1'b0, 0, 1'b0, '0, 1'b0, '0, 1'b1));
            end
         end
         CMD_FILL: begin
            w = install_line(s, addr);
         end
         CMD_WRITE: begin
            w = find_way(s, tag);
            if (w >= 0) begin
               touch_set(s, w);
               fresh_words.push_back(make_word(1'b1, w, 1'b0, '0, 1'b0, '0, 1'b1));
            end else begin
               w = install_line(s, addr);
            end
            line_dirty[s][w] = 1'b1;
         end
         default: begin
            for (w = 0; w < NUM_WAYS; w++) begin
               if (line_dirty[s][w]) begin
                  fresh_words.push_back(make_word(1'b0, w, 1'b1, stored_line(s, w),
                                                  1'b0, '0, 1'b0));
                  line_dirty[s][w] = 1'b0;
                  n++;
               end
            end
            if (n == 0) begin
               fresh_words.push_back(make_word(1'b0, 0, 1'b0, '0, 1'b0, '0, 1'b1));
            end else begin
               fresh_words[fresh_words.size() - 1].last_result = 1'b1;
            end
         end
      endcase
   endfunction

   task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                          input bit typed, input rsp_type word);
      stim_row_type r;
      r.cmd   = cmd;
      r.addr  = addr;
      r.typed = typed;
      r.word  = word;
      stim_rows.push_back(r);
   endtask

   // Presents one request word, with a random gap first, and waits for its acceptance.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_addr  <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Runs the shadow model on an accepted word and queues what the block must return.
   task automatic record_word(input stim_row_type r);
      fresh_words.delete();
      apply_cache_cmd(r.cmd, r.addr);
      if (r.typed) begin
         awaited_words.push_back(r.word);
      end else begin
         foreach (fresh_words[i]) awaited_words.push_back(fresh_words[i]);
      end
   endtask

   function automatic void compare_field(input string name, input logic [ADDR_W-1:0] want,
                                         input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // The consumer stalls at random outside the calm stretch.
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Every accepted response word is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_words.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual way %0d", $time,
                     rsp_way);
            mismatch_count++;
         end else begin
            want = awaited_words.pop_front();
            compare_field("hit", ADDR_W'(want.hit), ADDR_W'(rsp_hit));
            compare_field("way", ADDR_W'(want.way), ADDR_W'(rsp_way));
            compare_field("writeback_valid", ADDR_W'(want.writeback_valid),
                          ADDR_W'(rsp_writeback_valid));
            compare_field("writeback_addr", want.writeback_addr, rsp_writeback_addr);
            compare_field("fill_valid", ADDR_W'(want.fill_valid), ADDR_W'(rsp_fill_valid));
            compare_field("fill_addr", want.fill_addr, rsp_fill_addr);
            compare_field("last_result", ADDR_W'(want.last_result), ADDR_W'(rsp_last_result));
         end
      end
   end

   // The run is stopped when no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int k;
      int r;
      logic [31:0] raw;
      logic [CMD_W-1:0] cmd;
      logic [ADDR_W-1:0] addr;
      logic [TAG_FIELD_W-1:0] tag_pool [TAG_POOL];
      logic [SET_FIELD_W-1:0] hot_sets [3];
      rsp_type none;

      none = make_word(1'b0, 0, 1'b0, '0, 1'b0, '0, 1'b0);
      foreach (line_valid[s, w]) begin
         line_valid[s][w] = 1'b0;
         line_dirty[s][w] = 1'b0;
         line_tag[s][w]   = '0;
         line_age[s][w]   = '0;
      end

      // Empty cache: a zero tag does not hit, and a flush of a clean set gives one blank word.
      add_row(CMD_PROBE, 25'h0000000, 1'b1, make_word(1'b0, 0, 1'b0, '0, 1'b0, '0, 1'b1));
      add_row(CMD_FLUSH, 25'h0000000, 1'b1, make_word(1'b0, 0, 1'b0, '0, 1'b0, '0, 1'b1));
      // All-ones address: fill, hit, dirty write, flush, second clean flush; zero: fill, hit.
      add_row(CMD_FILL, 25'h1FFFFFF, 1'b1,
              make_word(1'b0, 0, 1'b0, '0, 1'b1, 25'h1FFFFE0, 1'b1));
      add_row(CMD_PROBE, 25'h1FFFFFF, 1'b1, make_word(1'b1, 0, 1'b0, '0, 1'b0, '0, 1'b1));
      add_row(CMD_WRITE, 25'h1FFFFE0, 1'b1, make_word(1'b1, 0, 1'b0, '0, 1'b0, '0, 1'b1));
      add_row(CMD_FLUSH, 25'h1FFFFFF, 1'b1,
              make_word(1'b0, 0, 1'b1, 25'h1FFFFE0, 1'b0, '0, 1'b1));
      add_row(CMD_FLUSH, 25'h1FFFFE0, 1'b1, make_word(1'b0, 0, 1'b0, '0, 1'b0, '0, 1'b1));
      add_row(CMD_FILL, 25'h0000000, 1'b1, make_word(1'b0, 0, 1'b0, '0, 1'b1, '0, 1'b1));
      add_row(CMD_PROBE, 25'h0000000, 1'b1, make_word(1'b1, 0, 1'b0, '0, 1'b0, '0, 1'b1));
      // Fill the top set with dirty lines, then force a dirty eviction.
      for (k = 0; k < NUM_WAYS; k++) begin
         add_row(CMD_WRITE, {13'(k), 7'h7F, 5'(k * 3)}, 1'b0, none);
      end
      add_row(CMD_WRITE, {13'h1FFF, 7'h7F, 5'h1F}, 1'b0, none);
      // A fill of a line already present installs a second copy.
      add_row(CMD_FILL, {13'h0003, 7'h7F, 5'h00}, 1'b0, none);
      add_row(CMD_PROBE, {13'h0005, 7'h7F, 5'h11}, 1'b0, none);
      add_row(CMD_PROBE, {13'h1234, 7'h7F, 5'h0A}, 1'b0, none);
      add_row(CMD_FLUSH, {13'h0AAA, 7'h7F, 5'h15}, 1'b0, none);
      add_row(CMD_FLUSH, {13'h1555, 7'h7F, 5'h0A}, 1'b0, none);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         send_word(stim_rows[i].cmd, stim_rows[i].addr);
         record_word(stim_rows[i]);
      end

      // A few hot sets and a tag pool larger than the ways keep hits and evictions frequent.
      hot_sets[0] = '0;
      hot_sets[1] = '1;
      hot_sets[2] = SET_FIELD_W'($urandom_range(NUM_SETS - 1));
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (k = 2; k < TAG_POOL; k++) tag_pool[k] = TAG_FIELD_W'($urandom);

      for (k = 0; k < RAND_WORDS; k++) begin
         calm = (k >= CALM_FIRST && k < CALM_LAST);
         r = $urandom_range(99);
         cmd = (r < 35) ? CMD_PROBE : (r < 50) ? CMD_FILL : (r < 85) ? CMD_WRITE : CMD_FLUSH;
         raw = $urandom;
         if ($urandom_range(99) < 15) begin
            addr = raw[ADDR_W-1:0];
         end else begin
            addr = {tag_pool[$urandom_range(TAG_POOL - 1)], hot_sets[$urandom_range(2)],
                    raw[OFF_W-1:0]};
         end
         send_word(cmd, addr);
         record_word(stim_row_type'{cmd, addr, 1'b0, none});
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (awaited_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
